[hw/rtl/tksd_pkg.sv]
// types, codes and the escape sequence rom of the terminal key sequence decoder
// no dependencies
package tksd_pkg;

   localparam logic [7:0] ESC_BYTE   = 8'h1b;
   localparam logic [7:0] DEL_BYTE   = 8'h7f;
   localparam logic [7:0] TAB_BYTE   = 8'h09;
   localparam logic [7:0] LF_BYTE    = 8'h0a;
   localparam logic [7:0] SPACE_BYTE = 8'h20;

   localparam logic [4:0] KEY_NONE   = 5'd0;
   localparam logic [4:0] KEY_ESC    = 5'd1;
   localparam logic [4:0] KEY_TAB    = 5'd2;
   localparam logic [4:0] KEY_RETURN = 5'd3;
   localparam logic [4:0] KEY_BKSP   = 5'd4;
   localparam logic [4:0] KEY_LAST   = 5'd26;

   localparam int WIN_LEN   = 7;
   localparam int ROM_COUNT = 229;
   localparam int IDX_W     = 8;
   localparam int LANES     = 8;
   localparam int LANE_W    = 3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       burst_end;
   } req_item_type;

   typedef struct packed {
      logic [4:0]  key_code;
      logic [20:0] key_char;
      logic        ctrl_mod;
      logic        alt_mod;
      logic        shift_mod;
      logic        last_key;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]  len;
      logic [55:0] seq;
      logic [4:0]  code;
      logic [2:0]  mods;
   } rom_entry_type;

   // seq is left aligned: byte j sits at bits [(6-j)*8 +: 8]
   function automatic rom_entry_type rom_mk(input logic [55:0] s, input logic [4:0] c,
                                            input logic [2:0] m);
      rom_entry_type e;
      int n;
      n = 0;
      for (int j = 0; j < WIN_LEN; j++) begin
         if (s[j*8 +: 8] != 8'd0) n = n + 1;
      end
      e.len  = 3'(n);
      e.seq  = s << ((WIN_LEN - n) * 8);
      e.code = c;
      e.mods = m;
      return e;
   endfunction

   function automatic rom_entry_type rom_lookup(input logic [IDX_W-1:0] idx);
      rom_entry_type e;
      e = '0;
      case (idx)
         8'd0: e = rom_mk("\033[15;5~", 5'd19, 3'd1);   8'd1: e = rom_mk("\033[17;5~", 5'd20, 3'd1);
         8'd2: e = rom_mk("\033[18;5~", 5'd21, 3'd1);   8'd3: e = rom_mk("\033[19;5~", 5'd22, 3'd1);
         8'd4: e = rom_mk("\033[20;5~", 5'd23, 3'd1);   8'd5: e = rom_mk("\033[21;5~", 5'd24, 3'd1);
         8'd6: e = rom_mk("\033[23;5~", 5'd25, 3'd1);   8'd7: e = rom_mk("\033[24;5~", 5'd26, 3'd1);
         8'd8: e = rom_mk("\033[15;3~", 5'd19, 3'd2);   8'd9: e = rom_mk("\033[17;3~", 5'd20, 3'd2);
         8'd10: e = rom_mk("\033[18;3~", 5'd21, 3'd2);  8'd11: e = rom_mk("\033[19;3~", 5'd22, 3'd2);
         8'd12: e = rom_mk("\033[20;3~", 5'd23, 3'd2);  8'd13: e = rom_mk("\033[21;3~", 5'd24, 3'd2);
         8'd14: e = rom_mk("\033[23;3~", 5'd25, 3'd2);  8'd15: e = rom_mk("\033[24;3~", 5'd26, 3'd2);
         8'd16: e = rom_mk("\033[15;7~", 5'd19, 3'd3);  8'd17: e = rom_mk("\033[17;7~", 5'd20, 3'd3);
         8'd18: e = rom_mk("\033[18;7~", 5'd21, 3'd3);  8'd19: e = rom_mk("\033[19;7~", 5'd22, 3'd3);
         8'd20: e = rom_mk("\033[20;7~", 5'd23, 3'd3);  8'd21: e = rom_mk("\033[21;7~", 5'd24, 3'd3);
         8'd22: e = rom_mk("\033[23;7~", 5'd25, 3'd3);  8'd23: e = rom_mk("\033[24;7~", 5'd26, 3'd3);
         8'd24: e = rom_mk("\033[15;2~", 5'd19, 3'd4);  8'd25: e = rom_mk("\033[17;2~", 5'd20, 3'd4);
         8'd26: e = rom_mk("\033[18;2~", 5'd21, 3'd4);  8'd27: e = rom_mk("\033[19;2~", 5'd22, 3'd4);
         8'd28: e = rom_mk("\033[20;2~", 5'd23, 3'd4);  8'd29: e = rom_mk("\033[21;2~", 5'd24, 3'd4);
         8'd30: e = rom_mk("\033[23;2~", 5'd25, 3'd4);  8'd31: e = rom_mk("\033[24;2~", 5'd26, 3'd4);
         8'd32: e = rom_mk("\033[15;6~", 5'd19, 3'd5);  8'd33: e = rom_mk("\033[17;6~", 5'd20, 3'd5);
         8'd34: e = rom_mk("\033[18;6~", 5'd21, 3'd5);  8'd35: e = rom_mk("\033[19;6~", 5'd22, 3'd5);
         8'd36: e = rom_mk("\033[20;6~", 5'd23, 3'd5);  8'd37: e = rom_mk("\033[21;6~", 5'd24, 3'd5);
         8'd38: e = rom_mk("\033[23;6~", 5'd25, 3'd5);  8'd39: e = rom_mk("\033[24;6~", 5'd26, 3'd5);
         8'd40: e = rom_mk("\033[15;4~", 5'd19, 3'd6);  8'd41: e = rom_mk("\033[17;4~", 5'd20, 3'd6);
         8'd42: e = rom_mk("\033[18;4~", 5'd21, 3'd6);  8'd43: e = rom_mk("\033[19;4~", 5'd22, 3'd6);
         8'd44: e = rom_mk("\033[20;4~", 5'd23, 3'd6);  8'd45: e = rom_mk("\033[21;4~", 5'd24, 3'd6);
         8'd46: e = rom_mk("\033[23;4~", 5'd25, 3'd6);  8'd47: e = rom_mk("\033[24;4~", 5'd26, 3'd6);
         8'd48: e = rom_mk("\033[15;8~", 5'd19, 3'd7);  8'd49: e = rom_mk("\033[17;8~", 5'd20, 3'd7);
         8'd50: e = rom_mk("\033[18;8~", 5'd21, 3'd7);  8'd51: e = rom_mk("\033[19;8~", 5'd22, 3'd7);
         8'd52: e = rom_mk("\033[20;8~", 5'd23, 3'd7);  8'd53: e = rom_mk("\033[21;8~", 5'd24, 3'd7);
         8'd54: e = rom_mk("\033[23;8~", 5'd25, 3'd7);  8'd55: e = rom_mk("\033[24;8~", 5'd26, 3'd7);
         8'd56: e = rom_mk("\033\033[11~", 5'd15, 3'd2); 8'd57: e = rom_mk("\033\033[12~", 5'd16, 3'd2);
         8'd58: e = rom_mk("\033\033[13~", 5'd17, 3'd2); 8'd59: e = rom_mk("\033\033[14~", 5'd18, 3'd2);
         8'd60: e = rom_mk("\033\033[15~", 5'd19, 3'd2); 8'd61: e = rom_mk("\033\033[17~", 5'd20, 3'd2);
         8'd62: e = rom_mk("\033\033[18~", 5'd21, 3'd2); 8'd63: e = rom_mk("\033\033[19~", 5'd22, 3'd2);
         8'd64: e = rom_mk("\033\033[20~", 5'd23, 3'd2); 8'd65: e = rom_mk("\033\033[21~", 5'd24, 3'd2);
         8'd66: e = rom_mk("\033\033[23~", 5'd25, 3'd2); 8'd67: e = rom_mk("\033\033[24~", 5'd26, 3'd2);
         8'd68: e = rom_mk("\033[3;2~", 5'd4, 3'd4);    8'd69: e = rom_mk("\033[3;6~", 5'd4, 3'd5);
         8'd70: e = rom_mk("\033[3;4~", 5'd4, 3'd6);    8'd71: e = rom_mk("\033[3;8~", 5'd4, 3'd7);
         8'd72: e = rom_mk("\033[1;5A", 5'd5, 3'd1);    8'd73: e = rom_mk("\033[1;5B", 5'd6, 3'd1);
         8'd74: e = rom_mk("\033[1;5C", 5'd8, 3'd1);    8'd75: e = rom_mk("\033[1;5D", 5'd7, 3'd1);
         8'd76: e = rom_mk("\033[1;3A", 5'd5, 3'd2);    8'd77: e = rom_mk("\033[1;3B", 5'd6, 3'd2);
         8'd78: e = rom_mk("\033[1;3C", 5'd8, 3'd2);    8'd79: e = rom_mk("\033[1;3D", 5'd7, 3'd2);
         8'd80: e = rom_mk("\033[1;7A", 5'd5, 3'd3);    8'd81: e = rom_mk("\033[1;7B", 5'd6, 3'd3);
         8'd82: e = rom_mk("\033[1;7C", 5'd8, 3'd3);    8'd83: e = rom_mk("\033[1;7D", 5'd7, 3'd3);
         8'd84: e = rom_mk("\033[1;2A", 5'd5, 3'd4);    8'd85: e = rom_mk("\033[1;2B", 5'd6, 3'd4);
         8'd86: e = rom_mk("\033[1;2C", 5'd8, 3'd4);    8'd87: e = rom_mk("\033[1;2D", 5'd7, 3'd4);
         8'd88: e = rom_mk("\033[1;6A", 5'd5, 3'd5);    8'd89: e = rom_mk("\033[1;6B", 5'd6, 3'd5);
         8'd90: e = rom_mk("\033[1;6C", 5'd8, 3'd5);    8'd91: e = rom_mk("\033[1;6D", 5'd7, 3'd5);
         8'd92: e = rom_mk("\033[1;4A", 5'd5, 3'd6);    8'd93: e = rom_mk("\033[1;4B", 5'd6, 3'd6);
         8'd94: e = rom_mk("\033[1;4C", 5'd8, 3'd6);    8'd95: e = rom_mk("\033[1;4D", 5'd7, 3'd6);
         8'd96: e = rom_mk("\033[1;8A", 5'd5, 3'd7);    8'd97: e = rom_mk("\033[1;8B", 5'd6, 3'd7);
         8'd98: e = rom_mk("\033[1;8C", 5'd8, 3'd7);    8'd99: e = rom_mk("\033[1;8D", 5'd7, 3'd7);
         8'd100: e = rom_mk("\033[2;5~", 5'd9, 3'd1);   8'd101: e = rom_mk("\033[3;5~", 5'd10, 3'd1);
         8'd102: e = rom_mk("\033[1;5H", 5'd11, 3'd1);  8'd103: e = rom_mk("\033[1;5F", 5'd12, 3'd1);
         8'd104: e = rom_mk("\033[5;5~", 5'd13, 3'd1);  8'd105: e = rom_mk("\033[6;5~", 5'd14, 3'd1);
         8'd106: e = rom_mk("\033[2;3~", 5'd9, 3'd2);   8'd107: e = rom_mk("\033[3;3~", 5'd10, 3'd2);
         8'd108: e = rom_mk("\033[1;3H", 5'd11, 3'd2);  8'd109: e = rom_mk("\033[1;3F", 5'd12, 3'd2);
         8'd110: e = rom_mk("\033[5;3~", 5'd13, 3'd2);  8'd111: e = rom_mk("\033[6;3~", 5'd14, 3'd2);
         8'd112: e = rom_mk("\033[2;7~", 5'd9, 3'd3);   8'd113: e = rom_mk("\033[3;7~", 5'd10, 3'd3);
         8'd114: e = rom_mk("\033[1;7H", 5'd11, 3'd3);  8'd115: e = rom_mk("\033[1;7F", 5'd12, 3'd3);
         8'd116: e = rom_mk("\033[5;7~", 5'd13, 3'd3);  8'd117: e = rom_mk("\033[6;7~", 5'd14, 3'd3);
         8'd118: e = rom_mk("\033[2;2~", 5'd9, 3'd4);   8'd119: e = rom_mk("\033[3;2~", 5'd10, 3'd4);
         8'd120: e = rom_mk("\033[1;2H", 5'd11, 3'd4);  8'd121: e = rom_mk("\033[1;2F", 5'd12, 3'd4);
         8'd122: e = rom_mk("\033[5;2~", 5'd13, 3'd4);  8'd123: e = rom_mk("\033[6;2~", 5'd14, 3'd4);
         8'd124: e = rom_mk("\033[2;6~", 5'd9, 3'd5);   8'd125: e = rom_mk("\033[3;6~", 5'd10, 3'd5);
         8'd126: e = rom_mk("\033[1;6H", 5'd11, 3'd5);  8'd127: e = rom_mk("\033[1;6F", 5'd12, 3'd5);
         8'd128: e = rom_mk("\033[5;6~", 5'd13, 3'd5);  8'd129: e = rom_mk("\033[6;6~", 5'd14, 3'd5);
         8'd130: e = rom_mk("\033[2;4~", 5'd9, 3'd6);   8'd131: e = rom_mk("\033[3;4~", 5'd10, 3'd6);
         8'd132: e = rom_mk("\033[1;4H", 5'd11, 3'd6);  8'd133: e = rom_mk("\033[1;4F", 5'd12, 3'd6);
         8'd134: e = rom_mk("\033[5;4~", 5'd13, 3'd6);  8'd135: e = rom_mk("\033[6;4~", 5'd14, 3'd6);
         8'd136: e = rom_mk("\033[2;8~", 5'd9, 3'd7);   8'd137: e = rom_mk("\033[3;8~", 5'd10, 3'd7);
         8'd138: e = rom_mk("\033[1;8H", 5'd11, 3'd7);  8'd139: e = rom_mk("\033[1;8F", 5'd12, 3'd7);
         8'd140: e = rom_mk("\033[5;8~", 5'd13, 3'd7);  8'd141: e = rom_mk("\033[6;8~", 5'd14, 3'd7);
         8'd142: e = rom_mk("\033[11~", 5'd15, 3'd0);   8'd143: e = rom_mk("\033[12~", 5'd16, 3'd0);
         8'd144: e = rom_mk("\033[13~", 5'd17, 3'd0);   8'd145: e = rom_mk("\033[14~", 5'd18, 3'd0);
         8'd146: e = rom_mk("\033[15~", 5'd19, 3'd0);   8'd147: e = rom_mk("\033[17~", 5'd20, 3'd0);
         8'd148: e = rom_mk("\033[18~", 5'd21, 3'd0);   8'd149: e = rom_mk("\033[19~", 5'd22, 3'd0);
         8'd150: e = rom_mk("\033[20~", 5'd23, 3'd0);   8'd151: e = rom_mk("\033[21~", 5'd24, 3'd0);
         8'd152: e = rom_mk("\033[23~", 5'd25, 3'd0);   8'd153: e = rom_mk("\033[24~", 5'd26, 3'd0);
         8'd154: e = rom_mk("\033[23~", 5'd15, 3'd4);   8'd155: e = rom_mk("\033[24~", 5'd16, 3'd4);
         8'd156: e = rom_mk("\033[25~", 5'd17, 3'd4);   8'd157: e = rom_mk("\033[26~", 5'd18, 3'd4);
         8'd158: e = rom_mk("\033[28~", 5'd19, 3'd4);   8'd159: e = rom_mk("\033[29~", 5'd20, 3'd4);
         8'd160: e = rom_mk("\033[31~", 5'd21, 3'd4);   8'd161: e = rom_mk("\033[32~", 5'd22, 3'd4);
         8'd162: e = rom_mk("\033[33~", 5'd23, 3'd4);   8'd163: e = rom_mk("\033[34~", 5'd24, 3'd4);
         8'd164: e = rom_mk("\033[23~", 5'd25, 3'd4);   8'd165: e = rom_mk("\033[24~", 5'd26, 3'd4);
         8'd166: e = rom_mk("\033\033[2~", 5'd9, 3'd2);  8'd167: e = rom_mk("\033\033[3~", 5'd10, 3'd2);
         8'd168: e = rom_mk("\033\033[1~", 5'd11, 3'd2); 8'd169: e = rom_mk("\033\033[4~", 5'd12, 3'd2);
         8'd170: e = rom_mk("\033\033[5~", 5'd13, 3'd2); 8'd171: e = rom_mk("\033\033[6~", 5'd14, 3'd2);
         8'd172: e = rom_mk("\033[2~", 5'd9, 3'd0);     8'd173: e = rom_mk("\033[3~", 5'd10, 3'd0);
         8'd174: e = rom_mk("\033[1~", 5'd11, 3'd0);    8'd175: e = rom_mk("\033[4~", 5'd12, 3'd0);
         8'd176: e = rom_mk("\033[5~", 5'd13, 3'd0);    8'd177: e = rom_mk("\033[6~", 5'd14, 3'd0);
         8'd178: e = rom_mk("\033\033[A", 5'd5, 3'd2);  8'd179: e = rom_mk("\033\033[B", 5'd6, 3'd2);
         8'd180: e = rom_mk("\033\033[C", 5'd8, 3'd2);  8'd181: e = rom_mk("\033\033[D", 5'd7, 3'd2);
         8'd182: e = rom_mk("\033\033OA", 5'd5, 3'd3);  8'd183: e = rom_mk("\033\033OB", 5'd6, 3'd3);
         8'd184: e = rom_mk("\033\033OC", 5'd8, 3'd3);  8'd185: e = rom_mk("\033\033OD", 5'd7, 3'd3);
         8'd186: e = rom_mk("\033O5P", 5'd15, 3'd1);    8'd187: e = rom_mk("\033O5Q", 5'd16, 3'd1);
         8'd188: e = rom_mk("\033O5R", 5'd17, 3'd1);    8'd189: e = rom_mk("\033O5S", 5'd18, 3'd1);
         8'd190: e = rom_mk("\033O3P", 5'd15, 3'd2);    8'd191: e = rom_mk("\033O3Q", 5'd16, 3'd2);
         8'd192: e = rom_mk("\033O3R", 5'd17, 3'd2);    8'd193: e = rom_mk("\033O3S", 5'd18, 3'd2);
         8'd194: e = rom_mk("\033O7P", 5'd15, 3'd3);    8'd195: e = rom_mk("\033O7Q", 5'd16, 3'd3);
         8'd196: e = rom_mk("\033O7R", 5'd17, 3'd3);    8'd197: e = rom_mk("\033O7S", 5'd18, 3'd3);
         8'd198: e = rom_mk("\033O2P", 5'd15, 3'd4);    8'd199: e = rom_mk("\033O2Q", 5'd16, 3'd4);
         8'd200: e = rom_mk("\033O2R", 5'd17, 3'd4);    8'd201: e = rom_mk("\033O2S", 5'd18, 3'd4);
         8'd202: e = rom_mk("\033O6P", 5'd15, 3'd5);    8'd203: e = rom_mk("\033O6Q", 5'd16, 3'd5);
         8'd204: e = rom_mk("\033O6R", 5'd17, 3'd5);    8'd205: e = rom_mk("\033O6S", 5'd18, 3'd5);
         8'd206: e = rom_mk("\033O4P", 5'd15, 3'd6);    8'd207: e = rom_mk("\033O4Q", 5'd16, 3'd6);
         8'd208: e = rom_mk("\033O4R", 5'd17, 3'd6);    8'd209: e = rom_mk("\033O4S", 5'd18, 3'd6);
         8'd210: e = rom_mk("\033O8P", 5'd15, 3'd7);    8'd211: e = rom_mk("\033O8Q", 5'd16, 3'd7);
         8'd212: e = rom_mk("\033O8R", 5'd17, 3'd7);    8'd213: e = rom_mk("\033O8S", 5'd18, 3'd7);
         8'd214: e = rom_mk("\033[A", 5'd5, 3'd0);      8'd215: e = rom_mk("\033[B", 5'd6, 3'd0);
         8'd216: e = rom_mk("\033[C", 5'd8, 3'd0);      8'd217: e = rom_mk("\033[D", 5'd7, 3'd0);
         8'd218: e = rom_mk("\033OA", 5'd5, 3'd1);      8'd219: e = rom_mk("\033OB", 5'd6, 3'd1);
         8'd220: e = rom_mk("\033OC", 5'd8, 3'd1);      8'd221: e = rom_mk("\033OD", 5'd7, 3'd1);
         8'd222: e = rom_mk("\033[Z", 5'd2, 3'd4);
         8'd223: e = rom_mk("\033OP", 5'd15, 3'd0);     8'd224: e = rom_mk("\033OQ", 5'd16, 3'd0);
         8'd225: e = rom_mk("\033OR", 5'd17, 3'd0);     8'd226: e = rom_mk("\033OS", 5'd18, 3'd0);
         8'd227: e = rom_mk("\033[H", 5'd11, 3'd0);     8'd228: e = rom_mk("\033[F", 5'd12, 3'd0);
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

[hw/rtl/terminal_key_sequence_decoder_core.sv]
// terminal key sequence decoder top level: byte buffer memory, rom scan and key decode
// depends on tksd_pkg
//
// Bytes enter one per item into a circular lookahead memory. A byte that neither ends a
// burst nor fills the buffer is absorbed without resolving a key. Otherwise keys are
// resolved one at a time: the window at the current position is read from the memory
// through its registered read port, the escape sequence rom is scanned 8 entries a cycle
// over the first min(229, TABLE_ENTRIES) entries, ending early on a hit, and the key is
// decoded and registered once the output is free. The rom scan dominates the time per
// key. A new byte is taken while the last key waits.
module terminal_key_sequence_decoder_core
   import tksd_pkg::*;
#(
   parameter int MAX_SEQ_LEN   = 7,
   parameter int TABLE_ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int AW = (MAX_SEQ_LEN > 1) ? $clog2(MAX_SEQ_LEN) : 1;
   localparam int CW = $clog2(MAX_SEQ_LEN + 1);
   localparam int SW = CW + 2;
   localparam int SCAN_LIMIT  = (ROM_COUNT < TABLE_ENTRIES) ? ROM_COUNT : TABLE_ENTRIES;
   localparam int SCAN_GROUPS = (SCAN_LIMIT + LANES - 1) / LANES;
   localparam int GW = (SCAN_GROUPS > 1) ? $clog2(SCAN_GROUPS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] nkey_ff, nkey_in;
   logic          end_ff, end_in;
   logic [2:0]    ld_ff, ld_in;
   logic [GW-1:0] grp_ff, grp_in;
   logic          found_ff, found_in;
   logic [4:0]    hcode_ff, hcode_in;
   logic [2:0]    hmods_ff, hmods_in;
   logic [2:0]    hlen_ff, hlen_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;
   logic [7:0]    win_ff [WIN_LEN];
   logic [7:0]    win_in [WIN_LEN];

   logic [7:0]    buf_mem [MAX_SEQ_LEN];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [SW-1:0] rd_sum, wr_sum, hd_sum;

   logic [CW-1:0] avail;
   logic          out_free;
   logic          accept;

   // scan lanes
   logic [LANES-1:0] lane_hit;
   rom_entry_type    lane_e [LANES];
   logic [IDX_W-1:0] lane_idx [LANES];
   logic             any_hit;
   rom_entry_type    pick_e;

   // key decode
   logic          k0;
   logic [CW-1:0] rem;
   logic [7:0]    lead;
   logic [2:0]    need;
   logic [2:0]    take;
   logic [7:0]    cb [4];
   logic [20:0]   ch;
   logic [4:0]    d_code;
   logic [2:0]    d_mods;
   logic [CW-1:0] used;
   logic [CW-1:0] pos_next;
   logic          is_last;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign avail     = count_ff - pos_ff;

   // circular addressing
   always_comb begin
      rd_sum = SW'(head_ff) + SW'(pos_ff) + SW'(ld_ff);
      if (rd_sum >= SW'(2 * MAX_SEQ_LEN)) rd_sum = rd_sum - SW'(2 * MAX_SEQ_LEN);
      else if (rd_sum >= SW'(MAX_SEQ_LEN)) rd_sum = rd_sum - SW'(MAX_SEQ_LEN);
      rd_addr = AW'(rd_sum);
      wr_sum = SW'(head_ff) + SW'(count_ff);
      if (wr_sum >= SW'(MAX_SEQ_LEN)) wr_sum = wr_sum - SW'(MAX_SEQ_LEN);
      wr_addr = AW'(wr_sum);
      wr_en   = accept;
   end

   always_ff @(posedge clock) begin
      if (wr_en) buf_mem[wr_addr] <= req_item.in_byte;
      rd_data_ff <= buf_mem[rd_addr];
   end

   // rom lanes, lowest index wins
   always_comb begin
      any_hit = 1'b0;
      pick_e  = '0;
      for (int l = 0; l < LANES; l++) begin
         lane_idx[l] = (IDX_W'(grp_ff) << LANE_W) | IDX_W'(l);
         lane_e[l]   = rom_lookup(lane_idx[l]);
         lane_hit[l] = (32'(lane_idx[l]) < SCAN_LIMIT) && (lane_e[l].len != 3'd0) &&
                       ((CW + 1)'(lane_e[l].len) <= (CW + 1)'(avail));
         for (int j = 0; j < WIN_LEN; j++) begin
            if ((3'(j) < lane_e[l].len) &&
                (win_ff[j] != lane_e[l].seq[(WIN_LEN - 1 - j) * 8 +: 8]))
               lane_hit[l] = 1'b0;
         end
      end
      for (int l = LANES - 1; l >= 0; l--) begin
         if (lane_hit[l]) begin
            any_hit = 1'b1;
            pick_e  = lane_e[l];
         end
      end
   end

   // head decode
   always_comb begin
      k0   = (win_ff[0] == ESC_BYTE);
      rem  = avail - CW'(k0);
      lead = k0 ? win_ff[1] : win_ff[0];
      if (lead < 8'h80)      need = 3'd1;
      else if (lead < 8'he0) need = 3'd2;
      else if (lead < 8'hf0) need = 3'd3;
      else                   need = 3'd4;
      take = ((CW + 1)'(need) < (CW + 1)'(rem)) ? need : 3'(rem);
      for (int j = 0; j < 4; j++) begin
         cb[j] = (3'(j) < take) ? (k0 ? win_ff[j + 1] : win_ff[j]) : 8'd0;
      end
      case (need)
         3'd1: ch = 21'(cb[0]);
         3'd2: ch = 21'({cb[0][4:0], cb[1][5:0]});
         3'd3: ch = 21'({cb[0][3:0], cb[1][5:0], cb[2][5:0]});
         default: ch = {cb[0][2:0], cb[1][5:0], cb[2][5:0], cb[3][5:0]};
      endcase
      d_code = KEY_NONE;
      d_mods = {1'b0, k0, 1'b0};
      if (ch >= 21'h41 && ch <= 21'h5a) d_mods[2] = 1'b1;
      if (ch == 21'(TAB_BYTE)) begin
         d_code = KEY_TAB;
         ch     = '0;
      end else if (ch == 21'(LF_BYTE)) begin
         d_code = KEY_RETURN;
         ch     = '0;
      end else if (ch == 21'(DEL_BYTE)) begin
         d_code = KEY_BKSP;
         ch     = '0;
      end else if (ch < 21'(SPACE_BYTE)) begin
         d_mods[0] = 1'b1;
         ch = (ch >= 21'd1 && ch <= 21'd26) ? ch + 21'h60 : ch + 21'h40;
      end
      used = CW'(k0) + CW'(take);
      if (found_ff) begin
         d_code = hcode_ff;
         d_mods = hmods_ff;
         ch     = '0;
         used   = CW'(hlen_ff);
      end else if (k0 && avail == CW'(1)) begin
         d_code = KEY_ESC;
         d_mods = '0;
         ch     = '0;
         used   = CW'(1);
      end
      pos_next = pos_ff + used;
      is_last  = !end_ff || (pos_next >= count_ff) || (nkey_ff == CW'(MAX_SEQ_LEN - 1));
      hd_sum   = SW'(head_ff) + SW'(used);
      if (hd_sum >= SW'(MAX_SEQ_LEN)) hd_sum = hd_sum - SW'(MAX_SEQ_LEN);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      pos_in       = pos_ff;
      nkey_in      = nkey_ff;
      end_in       = end_ff;
      ld_in        = ld_ff;
      grp_in       = grp_ff;
      found_in     = found_ff;
      hcode_in     = hcode_ff;
      hmods_in     = hmods_ff;
      hlen_in      = hlen_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      win_in       = win_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = count_ff + CW'(1);
               end_in   = req_item.burst_end;
               pos_in   = '0;
               nkey_in  = '0;
               ld_in    = '0;
               if (req_item.burst_end || (count_ff + CW'(1) == CW'(MAX_SEQ_LEN)))
                  state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (ld_ff != 3'd0) win_in[ld_ff - 3'd1] = rd_data_ff;
            if (ld_ff == 3'(WIN_LEN)) begin
               grp_in   = '0;
               state_in = ST_SCAN;
            end else begin
               ld_in = ld_ff + 3'd1;
            end
         end
         ST_SCAN: begin
            if (any_hit) begin
               found_in = 1'b1;
               hcode_in = pick_e.code;
               hmods_in = pick_e.mods;
               hlen_in  = pick_e.len;
               state_in = ST_EMIT;
            end else if (grp_ff == GW'(SCAN_GROUPS - 1)) begin
               found_in = 1'b0;
               state_in = ST_EMIT;
            end else begin
               grp_in = grp_ff + GW'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_item_in.key_code  = d_code;
               rsp_item_in.key_char  = ch;
               rsp_item_in.ctrl_mod  = d_mods[0];
               rsp_item_in.alt_mod   = d_mods[1];
               rsp_item_in.shift_mod = d_mods[2];
               rsp_item_in.last_key  = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
                  if (end_ff) begin
                     count_in = '0;
                     head_in  = '0;
                  end else begin
                     count_in = count_ff - used;
                     head_in  = AW'(hd_sum);
                  end
               end else begin
                  pos_in   = pos_next;
                  nkey_in  = nkey_ff + CW'(1);
                  ld_in    = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      nkey_ff     <= nkey_in;
      end_ff      <= end_in;
      ld_ff       <= ld_in;
      grp_ff      <= grp_in;
      found_ff    <= found_in;
      hcode_ff    <= hcode_in;
      hmods_ff    <= hmods_in;
      hlen_ff     <= hlen_in;
      rsp_item_ff <= rsp_item_in;
      win_ff      <= win_in;
   end

endmodule

[hw/rtl/tksd_checker.sv]
// port level checks for the terminal key sequence decoder, bound to its top level
// depends on tksd_pkg and terminal_key_sequence_decoder_core
module tksd_port_assertions
   import tksd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_item_type req_item,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled item changed");

   a_named_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.key_code != KEY_NONE |-> rsp_item.key_char == 21'd0)
      else $error("named key carries a character");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.key_code <= KEY_LAST)
      else $error("key code out of range");

   a_burst_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_item.burst_end |=> !req_ready)
      else $error("burst end did not start resolution");

endmodule

bind terminal_key_sequence_decoder_core tksd_port_assertions u_tksd_port_assertions (.*);

[test/tksd_checker.sv]
`timescale 1ns / 1ps
// checker for the terminal key sequence decoder: keeps its own byte buffer and rom,
// predicts the keys of every accepted item and compares them in order; uses tksd_pkg
module tksd_checker
   import tksd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_item,
   output int           fail_count,
   output int           keys_pending,
   output int           keys_seen
);

   localparam int SEQ_MAX = 7;

   typedef struct {
      int          len;
      logic [7:0]  seq [8];
      logic [4:0]  code;
      logic [2:0]  mods;
   } seq_entry_type;

   seq_entry_type seq_table [$];
   logic [7:0]    held_bytes [SEQ_MAX];
   int            held_count;
   rsp_item_type  expected_keys [$];

   function automatic void add_seq(input string s, input int code, input int mods);
      seq_entry_type e;
      e.len = s.len();
      for (int j = 0; j < 8; j++) e.seq[j] = (j < s.len()) ? s[j] : 8'd0;
      e.code = 5'(code);
      e.mods = 3'(mods);
      seq_table.push_back(e);
   endfunction

   // build the xterm/vt100 sequence table in priority order
   initial begin
      string fk [8];
      string ak [4];
      string sk [6];
      int    kc [4];
      fk = '{"15", "17", "18", "19", "20", "21", "23", "24"};
      ak = '{"A", "B", "C", "D"};
      kc = '{5, 6, 8, 7};
      for (int m = 0; m < 7; m++) begin
         int mv [7];
         mv = '{5, 3, 7, 2, 6, 4, 8};
         for (int f = 0; f < 8; f++)
            add_seq({"\033[", fk[f], ";", $sformatf("%0d", mv[m]), "~"}, 19 + f, m + 1);
      end
      begin
         string f12 [12];
         f12 = '{"11", "12", "13", "14", "15", "17", "18", "19", "20", "21", "23", "24"};
         for (int f = 0; f < 12; f++) add_seq({"\033\033[", f12[f], "~"}, 15 + f, 2);
      end
      add_seq("\033[3;2~", 4, 4); add_seq("\033[3;6~", 4, 5);
      add_seq("\033[3;4~", 4, 6); add_seq("\033[3;8~", 4, 7);
      begin
         int mv [7];
         mv = '{5, 3, 7, 2, 6, 4, 8};
         for (int m = 0; m < 7; m++)
            for (int a = 0; a < 4; a++)
               add_seq({"\033[1;", $sformatf("%0d", mv[m]), ak[a]}, kc[a], m + 1);
         for (int m = 0; m < 7; m++) begin
            string d;
            d = $sformatf("%0d", mv[m]);
            add_seq({"\033[2;", d, "~"}, 9, m + 1);
            add_seq({"\033[3;", d, "~"}, 10, m + 1);
            add_seq({"\033[1;", d, "H"}, 11, m + 1);
            add_seq({"\033[1;", d, "F"}, 12, m + 1);
            add_seq({"\033[5;", d, "~"}, 13, m + 1);
            add_seq({"\033[6;", d, "~"}, 14, m + 1);
         end
      end
      begin
         string f12 [12];
         string s12 [12];
         f12 = '{"11", "12", "13", "14", "15", "17", "18", "19", "20", "21", "23", "24"};
         s12 = '{"23", "24", "25", "26", "28", "29", "31", "32", "33", "34", "23", "24"};
         for (int f = 0; f < 12; f++) add_seq({"\033[", f12[f], "~"}, 15 + f, 0);
         for (int f = 0; f < 12; f++) add_seq({"\033[", s12[f], "~"}, 15 + f, 4);
      end
      sk = '{"2", "3", "1", "4", "5", "6"};
      for (int k = 0; k < 6; k++) add_seq({"\033\033[", sk[k], "~"}, 9 + k, 2);
      for (int k = 0; k < 6; k++) add_seq({"\033[", sk[k], "~"}, 9 + k, 0);
      for (int a = 0; a < 4; a++) add_seq({"\033\033[", ak[a]}, kc[a], 2);
      for (int a = 0; a < 4; a++) add_seq({"\033\033O", ak[a]}, kc[a], 3);
      begin
         string pk [4];
         int    mv [7];
         pk = '{"P", "Q", "R", "S"};
         mv = '{5, 3, 7, 2, 6, 4, 8};
         for (int m = 0; m < 7; m++)
            for (int p = 0; p < 4; p++)
               add_seq({"\033O", $sformatf("%0d", mv[m]), pk[p]}, 15 + p, m + 1);
         for (int a = 0; a < 4; a++) add_seq({"\033[", ak[a]}, kc[a], 0);
         for (int a = 0; a < 4; a++) add_seq({"\033O", ak[a]}, kc[a], 1);
         add_seq("\033[Z", KEY_TAB, 4);
         for (int p = 0; p < 4; p++) add_seq({"\033O", pk[p]}, 15 + p, 0);
      end
      add_seq("\033[H", 11, 0);
      add_seq("\033[F", 12, 0);
   end

   // decode one key at pos, push it, return bytes used
   function automatic int decode_key(input int pos);
      int          avail, k0, rem, need, take;
      logic [2:0]  mods;
      logic [4:0]  code;
      logic [20:0] ch;
      logic [7:0]  c [4];
      logic [7:0]  lead;
      rsp_item_type r;
      avail = held_count - pos;
      for (int i = 0; i < seq_table.size(); i++) begin
         bit hit;
         if (seq_table[i].len > avail) continue;
         hit = 1;
         for (int j = 0; j < seq_table[i].len; j++)
            if (held_bytes[pos + j] != seq_table[i].seq[j]) hit = 0;
         if (hit) begin
            r = '0;
            r.key_code  = seq_table[i].code;
            r.ctrl_mod  = seq_table[i].mods[0];
            r.alt_mod   = seq_table[i].mods[1];
            r.shift_mod = seq_table[i].mods[2];
            expected_keys.push_back(r);
            return seq_table[i].len;
         end
      end
      mods = 3'b000;
      code = KEY_NONE;
      k0 = pos;
      if (held_bytes[pos] == ESC_BYTE) begin
         if (avail == 1) begin
            r = '0;
            r.key_code = KEY_ESC;
            expected_keys.push_back(r);
            return 1;
         end
         mods[1] = 1;
         k0 = pos + 1;
      end
      rem = held_count - k0;
      lead = held_bytes[k0];
      need = lead < 8'h80 ? 1 : lead < 8'he0 ? 2 : lead < 8'hf0 ? 3 : 4;
      take = need < rem ? need : rem;
      for (int j = 0; j < 4; j++) c[j] = (j < take) ? held_bytes[k0 + j] : 8'd0;
      case (need)
         1: ch = 21'(c[0]);
         2: ch = {10'd0, c[0][4:0], c[1][5:0]};
         3: ch = {5'd0, c[0][3:0], c[1][5:0], c[2][5:0]};
         default: ch = {c[0][2:0], c[1][5:0], c[2][5:0], c[3][5:0]};
      endcase
      if (ch >= 21'h41 && ch <= 21'h5a) mods[2] = 1;
      if (ch == 21'(TAB_BYTE)) begin
         code = KEY_TAB; ch = '0;
      end else if (ch == 21'(LF_BYTE)) begin
         code = KEY_RETURN; ch = '0;
      end else if (ch == 21'(DEL_BYTE)) begin
         code = KEY_BKSP; ch = '0;
      end else if (ch < 21'(SPACE_BYTE)) begin
         mods[0] = 1;
         ch = (ch >= 1 && ch <= 26) ? ch + 21'h60 : ch + 21'h40;
      end
      r = '0;
      r.key_code  = code;
      r.key_char  = ch;
      r.ctrl_mod  = mods[0];
      r.alt_mod   = mods[1];
      r.shift_mod = mods[2];
      expected_keys.push_back(r);
      return (k0 - pos) + take;
   endfunction

   task automatic predict_keys(input req_item_type it);
      int n, pos, used, base;
      n = 0;
      base = expected_keys.size();
      if (held_count < SEQ_MAX) begin
         held_bytes[held_count] = it.in_byte;
         held_count++;
      end
      if (it.burst_end) begin
         pos = 0;
         while (pos < held_count && n < SEQ_MAX) begin
            pos += decode_key(pos);
            n++;
         end
         held_count = 0;
      end else if (held_count >= SEQ_MAX) begin
         used = decode_key(0);
         n = 1;
         if (used > held_count) used = held_count;
         for (int j = 0; j + used < held_count; j++) held_bytes[j] = held_bytes[j + used];
         held_count -= used;
      end
      if (n > 0) expected_keys[base + n - 1].last_key = 1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         expected_keys.delete();
         fail_count <= 0;
         keys_seen  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            keys_seen <= keys_seen + 1;
            if (expected_keys.size() == 0) begin
               if (fail_count < 10) $display("unexpected key %p", rsp_item);
               fail_count <= fail_count + 1;
            end else begin
               rsp_item_type e;
               e = expected_keys.pop_front();
               if (e !== rsp_item) begin
                  if (fail_count < 10) $display("key mismatch: expected %p got %p", e, rsp_item);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_keys(req_item);
      end
      keys_pending <= expected_keys.size();
   end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// top of the terminal key sequence decoder testbench: clock, reset, byte stimulus in
// idling phases and the verdict; depends on tksd_pkg, tksd_checker and the decoder core
module tb;
   import tksd_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_ready;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_ready = 0;
   rsp_item_type rsp_item;
   int           fail_count, keys_pending, keys_seen;
   int           send_idle_pct = 0, recv_stall_pct = 0;
   int           items_sent = 0;

   terminal_key_sequence_decoder_core i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_item, .rsp_valid, .rsp_ready, .rsp_item
   );

   tksd_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_item, .rsp_valid, .rsp_ready, .rsp_item,
      .fail_count, .keys_pending, .keys_seen
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // valid stays up after an item so the next one can follow without a gap
   task automatic send_byte(input logic [7:0] b, input logic e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_item  <= '{in_byte: b, burst_end: e};
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // drop valid and wait until every expected key has come out
   task automatic drain_keys();
      req_valid <= 0;
      @(negedge clock);
      while (keys_pending != 0) @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic end_last);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], end_last && i == s.len() - 1);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return ESC_BYTE;
         1: return 8'($urandom_range(31));
         2: return 8'($urandom_range(8'h80, 8'hff));
         3: return DEL_BYTE;
         default: return 8'($urandom_range(8'h20, 8'h7e));
      endcase
   endfunction

   task automatic send_random_burst();
      int    kind;
      string s;
      kind = $urandom_range(9);
      if (kind < 5) begin
         string pool [10];
         pool = '{"\033[1;5A", "\033[15;2~", "\033\033[24~", "\033OP", "\033[Z", "\033[3~",
                  "\033O7S", "\033\033OB", "\033[H", "\033[6;8~"};
         s = pool[$urandom_range(9)];
         if ($urandom_range(3) == 0) s[$urandom_range(s.len() - 1)] = pick_byte();
         send_text(s, 1);
      end else if (kind < 7) begin
         int lead;
         lead = $urandom_range(2);
         send_byte(lead == 0 ? 8'($urandom_range(8'hc0, 8'hdf)) :
                   lead == 1 ? 8'($urandom_range(8'he0, 8'hef)) :
                   8'($urandom_range(8'hf0, 8'hff)), 0);
         for (int i = 0; i < lead + 1; i++)
            send_byte(8'($urandom_range(8'h80, 8'hbf)), i == lead);
      end else begin
         int n;
         n = $urandom_range(1, 12);
         for (int i = 0; i < n; i++) send_byte(pick_byte(), i == n - 1);
      end
   endtask

   initial begin
      int stall_phase [4][2];
      stall_phase = '{'{0, 0}, '{68, 0}, '{0, 68}, '{38, 38}};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_text("\033", 1);
      send_text("\033[15;5~", 1);
      send_text("\033\033[A", 1);
      send_text("\033[23~", 1);
      send_text("\033x", 1);
      send_byte(ESC_BYTE, 0); send_byte(8'h00, 1);
      send_text("\t\n\177", 0);
      send_byte(8'h00, 0);
      send_text("\001\032\033", 1);
      send_text("\037AZaz~ ", 0);
      send_byte(8'hc3, 0); send_byte(8'ha9, 1);
      send_byte(8'he2, 0); send_byte(8'h82, 0); send_byte(8'hac, 1);
      send_byte(8'hf4, 0); send_byte(8'h8f, 0); send_byte(8'hbf, 0); send_byte(8'hbf, 1);
      send_byte(8'hff, 0); send_byte(8'h80, 1);
      send_byte(8'hf0, 1);
      send_text("ABCDEFGHIJ", 1);
      drain_keys();
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = stall_phase[p][0];
         recv_stall_pct = stall_phase[p][1];
         while (items_sent < 60 + (p + 1) * 100) send_random_burst();
         drain_keys();
      end
      recv_stall_pct = 0;
      repeat (60) @(negedge clock);
      $display("sent %0d bytes: escape sequences, utf-8, control codes, broken bursts",
               items_sent);
      $display("checked %0d keys under four idling mixes", keys_seen);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
